// File: hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// assertion macros shared by the ray direction generator rtl
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define PRDG_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("%m: assertion failed");
`define PRDG_ASSERT_NORST(label, clk, prop) \
   label: assert property (@(posedge clk) prop) else $error("%m: assertion failed");
`else
`define PRDG_ASSERT(label, clk, rst, prop)
`define PRDG_ASSERT_NORST(label, clk, prop)
`endif
`endif

// File: hw/rtl/prdg_pkg.sv
// ---------------------------------------------------------------------------
// prdg_pkg
// shared constants and types of the pinhole ray direction generator
// ---------------------------------------------------------------------------
package prdg_pkg;

   localparam int COMPONENT_BITS = 21;
   localparam int PIXEL_BITS     = 12;
   localparam int PORT_PIX_BITS  = 12;
   localparam int VEC_BITS       = 63;
   localparam int DIM_BITS       = 13;
   localparam int FLOOR_BITS     = 20;
   localparam int DIR_BITS       = 18;
   localparam int INDEX_BITS     = 24;
   localparam int FRAC_BITS      = 16;
   localparam int QUOT_BITS      = FRAC_BITS + 1;
   localparam int MAG_LIMIT_BITS = 30;
   localparam int CSR_IDX_BITS   = 3;

   localparam logic [CSR_IDX_BITS-1:0] CSR_CORNER = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_ACROSS = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_DOWN   = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_WIDTH  = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_HEIGHT = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] CSR_FLOOR  = 3'd5;

   localparam logic [DIM_BITS-1:0]   WIDTH_RESET  = 13'd512;
   localparam logic [DIM_BITS-1:0]   HEIGHT_RESET = 13'd512;
   localparam logic [FLOOR_BITS-1:0] FLOOR_RESET  = 20'd1;

   typedef struct packed {
      logic [2:0]            neg;
      logic [INDEX_BITS-1:0] index;
      logic                  oor;
   } side_type;

endpackage

// File: hw/rtl/prdg_front.sv
// ---------------------------------------------------------------------------
// prdg_front
// vector build, sign and floor, range scaling and squared length
// ---------------------------------------------------------------------------
module prdg_front #(
   parameter int CB = prdg_pkg::COMPONENT_BITS,
   parameter int PB = prdg_pkg::PIXEL_BITS,
   parameter int MW = 34,
   parameter int AW = 30
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          pipe_en,
   input  logic                          in_valid,
   input  logic [PB-1:0]                 in_col,
   input  logic [PB-1:0]                 in_row,
   input  logic [prdg_pkg::VEC_BITS-1:0] corner,
   input  logic [prdg_pkg::VEC_BITS-1:0] across,
   input  logic [prdg_pkg::VEC_BITS-1:0] down,
   input  logic [prdg_pkg::DIM_BITS-1:0] width,
   input  logic [prdg_pkg::DIM_BITS-1:0] height,
   input  logic [prdg_pkg::FLOOR_BITS-1:0] floor_val,
   output logic                          out_valid,
   output logic [2*AW+1:0]               out_sum,
   output logic [3*AW-1:0]               out_mag,
   output prdg_pkg::side_type            out_side
);
   localparam int RW    = CB + PB + 2;
   localparam int PW    = CB + PB + 1;
   localparam int SW    = 2 * AW + 2;
   localparam int SBITS = $clog2(MW + 1);
   localparam int IPW   = PB + prdg_pkg::DIM_BITS;
   localparam int IXW   = IPW + 1;
   localparam int DB    = prdg_pkg::DIM_BITS;

   // stage 1: products
   logic                  valid_s1_ff;
   logic [PB-1:0]         col_s1_ff, row_s1_ff;
   logic signed [PW-1:0]  pa_s1_ff [3];
   logic signed [PW-1:0]  pd_s1_ff [3];
   logic [IPW-1:0]        ip_s1_ff;
   logic signed [PW-1:0]  pa_s1_in [3];
   logic signed [PW-1:0]  pd_s1_in [3];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         pa_s1_in[k] = $signed({1'b0, in_col}) * $signed(across[k*CB +: CB]);
         pd_s1_in[k] = $signed({1'b0, in_row}) * $signed(down[k*CB +: CB]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_s1_ff <= 1'b0;
      end else if (pipe_en) begin
         valid_s1_ff <= in_valid;
      end
      if (pipe_en) begin
         col_s1_ff <= in_col;
         row_s1_ff <= in_row;
         ip_s1_ff  <= IPW'(in_row * width);
         for (int k = 0; k < 3; k++) begin
            pa_s1_ff[k] <= pa_s1_in[k];
            pd_s1_ff[k] <= pd_s1_in[k];
         end
      end
   end

   // stage 2: sum, magnitude, floor, index
   logic              valid_s2_ff;
   logic [MW-1:0]     mag_s2_ff [3];
   logic [MW-1:0]     mag_s2_in [3];
   prdg_pkg::side_type side_s2_ff, side_s2_in;
   logic signed [RW-1:0] r_sum [3];
   logic [RW-1:0]     r_mag [3];
   logic [IXW-1:0]    idx_sum;
   logic [IXW+prdg_pkg::INDEX_BITS-1:0] idx_wide;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         r_sum[k] = RW'($signed(corner[k*CB +: CB])) + RW'(pa_s1_ff[k]) + RW'(pd_s1_ff[k]);
         side_s2_in.neg[k] = r_sum[k][RW-1];
         r_mag[k] = r_sum[k][RW-1] ? (~r_sum[k] + 1'b1) : r_sum[k];
         mag_s2_in[k] = (MW'(r_mag[k]) < MW'(floor_val)) ? MW'(floor_val) : MW'(r_mag[k]);
      end
      idx_sum = IXW'(ip_s1_ff) + IXW'(col_s1_ff);
      idx_wide = {{prdg_pkg::INDEX_BITS{1'b0}}, idx_sum};
      side_s2_in.index = idx_wide[prdg_pkg::INDEX_BITS-1:0];
      side_s2_in.oor = (DB'(col_s1_ff) >= width) || (DB'(row_s1_ff) >= height);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_s2_ff <= 1'b0;
      end else if (pipe_en) begin
         valid_s2_ff <= valid_s1_ff;
      end
      if (pipe_en) begin
         side_s2_ff <= side_s2_in;
         for (int k = 0; k < 3; k++) begin
            mag_s2_ff[k] <= mag_s2_in[k];
         end
      end
   end

   // stage 3: common scale so all magnitudes fit below the limit
   logic              valid_s3_ff;
   logic [AW-1:0]     a_s3_ff [3];
   prdg_pkg::side_type side_s3_ff;
   logic [MW-1:0]     m_max;
   logic [SBITS-1:0]  shamt;

   always_comb begin
      m_max = mag_s2_ff[0];
      if (mag_s2_ff[1] > m_max) begin
         m_max = mag_s2_ff[1];
      end
      if (mag_s2_ff[2] > m_max) begin
         m_max = mag_s2_ff[2];
      end
      shamt = '0;
      for (int i = AW; i < MW; i++) begin
         if (m_max[i]) begin
            shamt = SBITS'(i - AW + 1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_s3_ff <= 1'b0;
      end else if (pipe_en) begin
         valid_s3_ff <= valid_s2_ff;
      end
      if (pipe_en) begin
         side_s3_ff <= side_s2_ff;
         for (int k = 0; k < 3; k++) begin
            a_s3_ff[k] <= AW'(mag_s2_ff[k] >> shamt);
         end
      end
   end

   // stage 4: squares
   logic              valid_s4_ff;
   logic [AW-1:0]     a_s4_ff [3];
   logic [2*AW-1:0]   sq_s4_ff [3];
   prdg_pkg::side_type side_s4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_s4_ff <= 1'b0;
      end else if (pipe_en) begin
         valid_s4_ff <= valid_s3_ff;
      end
      if (pipe_en) begin
         side_s4_ff <= side_s3_ff;
         for (int k = 0; k < 3; k++) begin
            a_s4_ff[k]  <= a_s3_ff[k];
            sq_s4_ff[k] <= a_s3_ff[k] * a_s3_ff[k];
         end
      end
   end

   // stage 5: squared length
   logic              valid_s5_ff;
   logic [AW-1:0]     a_s5_ff [3];
   logic [SW-1:0]     sum_s5_ff;
   prdg_pkg::side_type side_s5_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_s5_ff <= 1'b0;
      end else if (pipe_en) begin
         valid_s5_ff <= valid_s4_ff;
      end
      if (pipe_en) begin
         side_s5_ff <= side_s4_ff;
         sum_s5_ff  <= SW'(sq_s4_ff[0]) + SW'(sq_s4_ff[1]) + SW'(sq_s4_ff[2]);
         for (int k = 0; k < 3; k++) begin
            a_s5_ff[k] <= a_s4_ff[k];
         end
      end
   end

   assign out_valid = valid_s5_ff;
   assign out_sum   = sum_s5_ff;
   assign out_mag   = {a_s5_ff[2], a_s5_ff[1], a_s5_ff[0]};
   assign out_side  = side_s5_ff;

endmodule

// File: hw/rtl/prdg_sqrt.sv
// ---------------------------------------------------------------------------
// prdg_sqrt
// pipelined integer square root, one root bit per stage
// ---------------------------------------------------------------------------
module prdg_sqrt #(
   parameter int NW  = 31,
   parameter int PLW = 8
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            pipe_en,
   input  logic            in_valid,
   input  logic [2*NW-1:0] in_rad,
   input  logic [PLW-1:0]  in_pl,
   output logic            out_valid,
   output logic [NW-1:0]   out_root,
   output logic [PLW-1:0]  out_pl
);
   logic            valid_ff [NW];
   logic [2*NW-1:0] rad_ff   [NW];
   logic [NW+1:0]   rem_ff   [NW];
   logic [NW-1:0]   root_ff  [NW];
   logic [PLW-1:0]  pl_ff    [NW];

   for (genvar i = 0; i < NW; i++) begin : g_step
      logic            v_prev;
      logic [2*NW-1:0] rad_prev;
      logic [NW+1:0]   rem_prev;
      logic [NW-1:0]   root_prev;
      logic [PLW-1:0]  pl_prev;
      logic [NW+3:0]   cur, trial, diff;
      logic            ge;

      if (i == 0) begin : g_first
         assign v_prev    = in_valid;
         assign rad_prev  = in_rad;
         assign rem_prev  = '0;
         assign root_prev = '0;
         assign pl_prev   = in_pl;
      end else begin : g_next
         assign v_prev    = valid_ff[i-1];
         assign rad_prev  = rad_ff[i-1];
         assign rem_prev  = rem_ff[i-1];
         assign root_prev = root_ff[i-1];
         assign pl_prev   = pl_ff[i-1];
      end

      assign cur   = {rem_prev, rad_prev[2*NW-1 -: 2]};
      assign trial = (NW+4)'({root_prev, 2'b01});
      assign diff  = cur - trial;
      assign ge    = cur >= trial;

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else if (pipe_en) begin
            valid_ff[i] <= v_prev;
         end
         if (pipe_en) begin
            rad_ff[i]  <= rad_prev << 2;
            rem_ff[i]  <= ge ? diff[NW+1:0] : cur[NW+1:0];
            root_ff[i] <= {root_prev[NW-2:0], ge};
            pl_ff[i]   <= pl_prev;
         end
      end
   end

   assign out_valid = valid_ff[NW-1];
   assign out_root  = root_ff[NW-1];
   assign out_pl    = pl_ff[NW-1];

endmodule

// File: hw/rtl/prdg_div.sv
// ---------------------------------------------------------------------------
// prdg_div
// three-lane pipelined restoring divider, one quotient bit per stage
// ---------------------------------------------------------------------------
module prdg_div #(
   parameter int AW = 30,
   parameter int NW = 31
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                pipe_en,
   input  logic                                in_valid,
   input  logic [NW-1:0]                       in_root,
   input  logic [3*AW-1:0]                     in_mag,
   input  prdg_pkg::side_type                  in_side,
   output logic                                out_valid,
   output logic                                out_zero,
   output logic [3*prdg_pkg::QUOT_BITS-1:0]    out_quot,
   output prdg_pkg::side_type                  out_side
);
   localparam int QW  = prdg_pkg::QUOT_BITS;
   localparam int RMW = AW + prdg_pkg::FRAC_BITS;
   localparam int CW  = AW + NW + QW;

   logic               valid_ff [QW];
   logic [NW-1:0]      div_ff   [QW];
   prdg_pkg::side_type side_ff  [QW];
   logic [RMW-1:0]     rem_ff   [QW][3];
   logic [QW-1:0]      quo_ff   [QW][3];

   for (genvar i = 0; i < QW; i++) begin : g_step
      logic               v_prev;
      logic [NW-1:0]      div_prev;
      prdg_pkg::side_type side_prev;
      logic [CW-1:0]      dsh;

      if (i == 0) begin : g_first
         assign v_prev    = in_valid;
         assign div_prev  = in_root;
         assign side_prev = in_side;
      end else begin : g_next
         assign v_prev    = valid_ff[i-1];
         assign div_prev  = div_ff[i-1];
         assign side_prev = side_ff[i-1];
      end

      assign dsh = CW'(div_prev) << (QW - 1 - i);

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else if (pipe_en) begin
            valid_ff[i] <= v_prev;
         end
         if (pipe_en) begin
            div_ff[i]  <= div_prev;
            side_ff[i] <= side_prev;
         end
      end

      for (genvar l = 0; l < 3; l++) begin : g_lane
         logic [RMW-1:0] rem_prev;
         logic [QW-1:0]  quo_prev;
         logic [CW-1:0]  remw, diff;
         logic           ge;

         if (i == 0) begin : g_first
            assign rem_prev = {in_mag[l*AW +: AW], {prdg_pkg::FRAC_BITS{1'b0}}};
            assign quo_prev = '0;
         end else begin : g_next
            assign rem_prev = rem_ff[i-1][l];
            assign quo_prev = quo_ff[i-1][l];
         end

         assign remw = CW'(rem_prev);
         assign ge   = remw >= dsh;
         assign diff = remw - dsh;

         always_ff @(posedge clock) begin
            if (pipe_en) begin
               rem_ff[i][l] <= ge ? diff[RMW-1:0] : rem_prev;
               quo_ff[i][l] <= {quo_prev[QW-2:0], ge};
            end
         end
      end
   end

   assign out_valid = valid_ff[QW-1];
   assign out_zero  = (div_ff[QW-1] == '0);
   assign out_quot  = {quo_ff[QW-1][2], quo_ff[QW-1][1], quo_ff[QW-1][0]};
   assign out_side  = side_ff[QW-1];

endmodule

// File: hw/rtl/pinhole_ray_direction_generator_top.sv
// ---------------------------------------------------------------------------
// pinhole_ray_direction_generator_top
// unit ray direction, pixel index and range flag for each pixel request
//
// requests carry a pixel column and row on req_* with valid and stall;
// results leave on rsp_* with the same handshake, one per request, in order.
// the csr_* port writes the camera vectors, image size and roundoff floor;
// write it only while no request is in flight.
// the pipeline has five front stages (products, sum and floor, scaling,
// squares, length), one stage per root bit in the square root, one stage
// per quotient bit in the three-lane divider, then the output register.
// throughput is one request per cycle while no stalled result is waiting.
// a stalled result holds in the output register and freezes every stage,
// so req_stall follows rsp_stall while a result is waiting.
// reset clears all valid bits and loads the register defaults (512 by 512
// image, floor 1, zero vectors).
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module pinhole_ray_direction_generator_top #(
   parameter int COMPONENT_BITS = prdg_pkg::COMPONENT_BITS,
   parameter int PIXEL_BITS     = prdg_pkg::PIXEL_BITS
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [prdg_pkg::PORT_PIX_BITS-1:0]    req_pixel_col,
   input  logic [prdg_pkg::PORT_PIX_BITS-1:0]    req_pixel_row,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [prdg_pkg::DIR_BITS-1:0]  rsp_dir_x,
   output logic signed [prdg_pkg::DIR_BITS-1:0]  rsp_dir_y,
   output logic signed [prdg_pkg::DIR_BITS-1:0]  rsp_dir_z,
   output logic [prdg_pkg::INDEX_BITS-1:0]       rsp_pixel_index,
   output logic                                  rsp_out_of_range,
   input  logic                                  csr_write,
   input  logic [prdg_pkg::CSR_IDX_BITS-1:0]     csr_index,
   input  logic [prdg_pkg::VEC_BITS-1:0]         csr_data
);
   localparam int RW = COMPONENT_BITS + PIXEL_BITS + 2;
   localparam int MW = (RW > prdg_pkg::FLOOR_BITS) ? RW : prdg_pkg::FLOOR_BITS;
   localparam int AW = (MW > prdg_pkg::MAG_LIMIT_BITS) ? prdg_pkg::MAG_LIMIT_BITS : MW;
   localparam int NW = AW + 1;
   localparam int SLW = $bits(prdg_pkg::side_type);
   localparam int PLW = 3 * AW + SLW;
   localparam int QW  = prdg_pkg::QUOT_BITS;
   localparam int DB  = prdg_pkg::DIR_BITS;

   // configuration registers
   logic [prdg_pkg::VEC_BITS-1:0]   corner_ff, across_ff, down_ff;
   logic [prdg_pkg::DIM_BITS-1:0]   width_ff, height_ff;
   logic [prdg_pkg::FLOOR_BITS-1:0] floor_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         corner_ff <= '0;
         across_ff <= '0;
         down_ff   <= '0;
         width_ff  <= prdg_pkg::WIDTH_RESET;
         height_ff <= prdg_pkg::HEIGHT_RESET;
         floor_ff  <= prdg_pkg::FLOOR_RESET;
      end else if (csr_write) begin
         case (csr_index)
            prdg_pkg::CSR_CORNER: corner_ff <= csr_data;
            prdg_pkg::CSR_ACROSS: across_ff <= csr_data;
            prdg_pkg::CSR_DOWN:   down_ff   <= csr_data;
            prdg_pkg::CSR_WIDTH:  width_ff  <= csr_data[prdg_pkg::DIM_BITS-1:0];
            prdg_pkg::CSR_HEIGHT: height_ff <= csr_data[prdg_pkg::DIM_BITS-1:0];
            prdg_pkg::CSR_FLOOR:  floor_ff  <= csr_data[prdg_pkg::FLOOR_BITS-1:0];
            default: ;
         endcase
      end
   end

   logic rsp_valid_ff;
   logic pipe_en;

   assign pipe_en   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !pipe_en;

   logic               fr_valid;
   logic [2*NW-1:0]    fr_sum;
   logic [3*AW-1:0]    fr_mag;
   prdg_pkg::side_type fr_side;

   prdg_front #(
      .CB(COMPONENT_BITS), .PB(PIXEL_BITS), .MW(MW), .AW(AW)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .pipe_en   (pipe_en),
      .in_valid  (req_valid && !req_stall),
      .in_col    (req_pixel_col[PIXEL_BITS-1:0]),
      .in_row    (req_pixel_row[PIXEL_BITS-1:0]),
      .corner    (corner_ff),
      .across    (across_ff),
      .down      (down_ff),
      .width     (width_ff),
      .height    (height_ff),
      .floor_val (floor_ff),
      .out_valid (fr_valid),
      .out_sum   (fr_sum),
      .out_mag   (fr_mag),
      .out_side  (fr_side)
   );

   logic               sq_valid;
   logic [NW-1:0]      sq_root;
   logic [PLW-1:0]     sq_pl;
   prdg_pkg::side_type sq_side;

   prdg_sqrt #(.NW(NW), .PLW(PLW)) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .pipe_en   (pipe_en),
      .in_valid  (fr_valid),
      .in_rad    (fr_sum),
      .in_pl     ({fr_mag, fr_side}),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_pl    (sq_pl)
   );

   assign sq_side = sq_pl[SLW-1:0];

   logic               dv_valid;
   logic               dv_zero;
   logic [3*QW-1:0]    dv_quot;
   prdg_pkg::side_type dv_side;

   prdg_div #(.AW(AW), .NW(NW)) u_div (
      .clock     (clock),
      .reset     (reset),
      .pipe_en   (pipe_en),
      .in_valid  (sq_valid),
      .in_root   (sq_root),
      .in_mag    (sq_pl[PLW-1:SLW]),
      .in_side   (sq_side),
      .out_valid (dv_valid),
      .out_zero  (dv_zero),
      .out_quot  (dv_quot),
      .out_side  (dv_side)
   );

   // output register
   logic signed [DB-1:0] dir_in [3];
   logic signed [DB-1:0] dir_ff [3];
   logic [prdg_pkg::INDEX_BITS-1:0] index_ff;
   logic oor_ff;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         if (dv_zero) begin
            dir_in[k] = '0;
         end else if (dv_side.neg[k]) begin
            dir_in[k] = -$signed(DB'(dv_quot[k*QW +: QW]));
         end else begin
            dir_in[k] = $signed(DB'(dv_quot[k*QW +: QW]));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         rsp_valid_ff <= dv_valid;
      end
      if (pipe_en) begin
         for (int k = 0; k < 3; k++) begin
            dir_ff[k] <= dir_in[k];
         end
         index_ff <= dv_side.index;
         oor_ff   <= dv_side.oor;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_dir_x        = dir_ff[0];
   assign rsp_dir_y        = dir_ff[1];
   assign rsp_dir_z        = dir_ff[2];
   assign rsp_pixel_index  = index_ff;
   assign rsp_out_of_range = oor_ff;

   `PRDG_ASSERT(a_dir_x_unit, clock, reset, rsp_valid |-> (rsp_dir_x >= -18'sd65536 && rsp_dir_x <= 18'sd65536))
   `PRDG_ASSERT(a_dir_y_unit, clock, reset, rsp_valid |-> (rsp_dir_y >= -18'sd65536 && rsp_dir_y <= 18'sd65536))
   `PRDG_ASSERT(a_dir_z_unit, clock, reset, rsp_valid |-> (rsp_dir_z >= -18'sd65536 && rsp_dir_z <= 18'sd65536))
   `PRDG_ASSERT_NORST(a_reset_empty, clock, reset |=> !rsp_valid)

endmodule
